/* design/slu_pkg.sv */
// Shared types and constants for the string literal unescaper.
// Holds the beat payload structs, character codes, error codes and the escape table.
// No dependencies.
package slu_pkg;

    // Long bracket limits
    localparam int MAX_LEVEL  = 14;
    localparam int TAIL_DEPTH = MAX_LEVEL + 2;
    localparam int LEVEL_W    = $clog2(MAX_LEVEL + 1);
    localparam int FILL_W     = $clog2(TAIL_DEPTH + 1);

    // Decimal escapes take at most this many digits
    localparam logic [1:0] DIGIT_MAX = 2'd3;

    // Character codes
    localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
    localparam logic [7:0] CH_LBR  = 8'h5B;  // '['
    localparam logic [7:0] CH_RBR  = 8'h5D;  // ']'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE = 8'h39;  // '9'
    localparam logic [7:0] CH_BSL  = 8'h5C;  // backslash
    localparam logic [7:0] CH_DQ   = 8'h22;  // double quote
    localparam logic [7:0] CH_SQ   = 8'h27;  // single quote
    localparam logic [7:0] CH_LF   = 8'h0A;  // newline

    // Error codes reported with the end of a literal
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_QUOTE     = 3'd1;
    localparam logic [2:0] ERR_OPEN      = 3'd2;
    localparam logic [2:0] ERR_CLOSE     = 3'd3;
    localparam logic [2:0] ERR_FIRST     = 3'd4;
    localparam logic [2:0] ERR_ESCAPE    = 3'd5;
    localparam logic [2:0] ERR_LAST_CODE = ERR_ESCAPE;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       literal_done;
        logic [2:0] error_code;
    } out_item_t;

    // Single-character escapes: bit 8 set when the escape is legal
    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'd7};   // a
            8'h62:   r = {1'b1, 8'd8};   // b
            8'h66:   r = {1'b1, 8'd12};  // f
            8'h6E:   r = {1'b1, 8'd10};  // n
            8'h72:   r = {1'b1, 8'd13};  // r
            8'h74:   r = {1'b1, 8'd9};   // t
            8'h76:   r = {1'b1, 8'd11};  // v
            CH_BSL, CH_DQ, CH_SQ, CH_LF: r = {1'b1, c};
            default: r = {1'b0, 8'd0};
        endcase
        return r;
    endfunction

endpackage

/* design/string_literal_unescaper_core.sv */
// String literal unescaper: top level.
// Decodes one quoted or long-bracket literal per run of input beats.
// Depends on slu_pkg.
//
// Usage:
//   s_item carries one raw byte of the literal, delimiters included, with
//   final_byte set on its last byte. m_result gives one or two result beats
//   per input beat; run_last marks the last of them, and on the final byte
//   that beat also carries literal_done and error_code.
//   The results of a byte are registered into the result queue when the byte
//   is taken. Throughput: one byte per cycle while each byte gives a single
//   result and the receiver takes every result; a byte that gives two results
//   (a decimal escape closed by the next byte) queues two result beats.
//   A three-entry result queue sits between the decoder and m_result; a new
//   byte is taken whenever at most one result is queued, so the input keeps
//   moving while a finished result waits to be taken.
//   When the receiver stalls, results hold steady on m_result and s_ready
//   drops once two results are queued.
//   Reset (aresetn low, synchronous) empties the queue and returns the
//   decoder to waiting for an opening delimiter. After every final byte the
//   decoder also returns there on its own.
module string_literal_unescaper_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slu_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output slu_pkg::out_item_t m_result
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_QUOTED,
        PH_ESCAPE,
        PH_DIGITS,
        PH_OPEN,
        PH_LONG,
        PH_SKIP
    } phase_t;

    localparam int QDEPTH = 3;

    // Decoder state
    phase_t                        phase_reg, phase_next;
    logic [7:0]                    quote_reg, quote_next;
    logic [slu_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [7:0]                    dval_reg, dval_next;
    logic [1:0]                    dcnt_reg, dcnt_next;
    logic                          first_reg, first_next;
    logic [slu_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [2:0]                    err_reg, err_next;
    logic [7:0]                    tail_reg [slu_pkg::TAIL_DEPTH];
    logic [7:0]                    tail_next [slu_pkg::TAIL_DEPTH];

    // Result queue
    slu_pkg::out_item_t            q_reg [QDEPTH];
    slu_pkg::out_item_t            q_next [QDEPTH];
    logic [1:0]                    cnt_reg, cnt_next;

    logic                          accept;
    logic                          pop;
    logic [1:0]                    cnt_pop;

    // Per-beat decode results
    logic [1:0]                    put_n;
    logic [7:0]                    put_b0, put_b1;
    slu_pkg::out_item_t            res0, res1;
    logic [1:0]                    res_n;

    logic [7:0]                    b;
    logic                          fin;
    logic                          is_digit;
    logic                          do_quoted;
    logic [8:0]                    esc;
    logic [slu_pkg::FILL_W-1:0]    lvl_plus2;
    logic                          shift_tail;
    logic                          close_ok;
    logic [2:0]                    err_next_final;

    assign b        = s_item.data_byte;
    assign fin      = s_item.final_byte;
    assign is_digit = (b >= slu_pkg::CH_ZERO) && (b <= slu_pkg::CH_NINE);
    assign esc      = slu_pkg::escape_map(b);
    assign lvl_plus2 = slu_pkg::FILL_W'(level_reg) + slu_pkg::FILL_W'(2);

    // Handshake
    assign s_ready  = (cnt_reg <= 2'd1);
    assign accept   = s_valid && s_ready;
    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign cnt_pop  = cnt_reg - {1'b0, pop};
    assign m_result = q_reg[0];

    // Byte decoder
    always_comb begin
        phase_next = phase_reg;
        quote_next = quote_reg;
        level_next = level_reg;
        dval_next  = dval_reg;
        dcnt_next  = dcnt_reg;
        first_next = first_reg;
        fill_next  = fill_reg;
        err_next   = err_reg;
        tail_next  = tail_reg;
        put_n      = 2'd0;
        put_b0     = 8'd0;
        put_b1     = 8'd0;
        do_quoted  = 1'b0;
        shift_tail = 1'b0;
        close_ok   = 1'b0;

        unique case (phase_reg)
            PH_QUOTED: begin
                do_quoted = 1'b1;
            end
            PH_ESCAPE: begin
                if (fin) begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_ESCAPE;
                    phase_next = PH_SKIP;
                end else if (is_digit) begin
                    dval_next  = b - slu_pkg::CH_ZERO;
                    dcnt_next  = 2'd1;
                    phase_next = PH_DIGITS;
                end else if (!esc[8]) begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_ESCAPE;
                    phase_next = PH_SKIP;
                end else begin
                    put_b0     = esc[7:0];
                    put_n      = 2'd1;
                    phase_next = PH_QUOTED;
                end
            end
            PH_DIGITS: begin
                if (!fin && is_digit) begin
                    // value * 10 + digit, kept to 8 bits
                    dval_next = (dval_reg << 3) + (dval_reg << 1) + (b - slu_pkg::CH_ZERO);
                    dcnt_next = dcnt_reg + 2'd1;
                    if (dcnt_next == slu_pkg::DIGIT_MAX) begin
                        put_b0     = dval_next;
                        put_n      = 2'd1;
                        phase_next = PH_QUOTED;
                    end
                end else begin
                    // emit the pending value, then treat this byte as body
                    put_b0     = dval_reg;
                    put_n      = 2'd1;
                    phase_next = PH_QUOTED;
                    do_quoted  = 1'b1;
                end
            end
            PH_OPEN: begin
                if (b == slu_pkg::CH_EQ) begin
                    if (level_reg >= slu_pkg::LEVEL_W'(slu_pkg::MAX_LEVEL)) begin
                        if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_OPEN;
                        phase_next = PH_SKIP;
                    end else begin
                        level_next = level_reg + 1'b1;
                    end
                end else if (b == slu_pkg::CH_LBR) begin
                    phase_next = PH_LONG;
                    first_next = 1'b1;
                    fill_next  = '0;
                    if (fin) begin
                        if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_CLOSE;
                        phase_next = PH_SKIP;
                    end
                end else begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_OPEN;
                    phase_next = PH_SKIP;
                end
                if (fin && phase_next == PH_OPEN) begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_OPEN;
                    phase_next = PH_SKIP;
                end
            end
            PH_LONG: begin
                first_next = 1'b0;
                if (!(first_reg && b == slu_pkg::CH_LF)) begin
                    if (fill_reg >= lvl_plus2) begin
                        // full: emit oldest held byte, shift the window
                        put_b0     = tail_reg[0];
                        put_n      = 2'd1;
                        shift_tail = 1'b1;
                    end else if (fill_reg < slu_pkg::FILL_W'(slu_pkg::TAIL_DEPTH)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    for (int k = 0; k < slu_pkg::TAIL_DEPTH; k++) begin
                        if (shift_tail) begin
                            if (slu_pkg::FILL_W'(k) == lvl_plus2 - 1'b1) begin
                                tail_next[k] = b;
                            end else if (k < slu_pkg::TAIL_DEPTH - 1 &&
                                         slu_pkg::FILL_W'(k) < lvl_plus2) begin
                                tail_next[k] = tail_reg[(k + 1) % slu_pkg::TAIL_DEPTH];
                            end
                        end else if (fill_next != fill_reg &&
                                     slu_pkg::FILL_W'(k) == fill_reg) begin
                            tail_next[k] = b;
                        end
                    end
                end
                // closing bracket check: window holds exactly level+2 bytes after this beat
                close_ok = (fill_next == lvl_plus2);
                for (int k = 0; k < slu_pkg::TAIL_DEPTH; k++) begin
                    if (k == 0 || slu_pkg::FILL_W'(k) == lvl_plus2 - 1'b1) begin
                        if (tail_next[k] != slu_pkg::CH_RBR) close_ok = 1'b0;
                    end else if (slu_pkg::FILL_W'(k) < lvl_plus2) begin
                        if (tail_next[k] != slu_pkg::CH_EQ) close_ok = 1'b0;
                    end
                end
                if (fin && !close_ok) begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_CLOSE;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                phase_next = PH_SKIP;
            end
            default: begin
                // waiting for the opening delimiter
                if (b == slu_pkg::CH_DQ || b == slu_pkg::CH_SQ) begin
                    quote_next = b;
                    phase_next = PH_QUOTED;
                    if (fin) begin
                        if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_QUOTE;
                        phase_next = PH_SKIP;
                    end
                end else if (b == slu_pkg::CH_LBR) begin
                    level_next = '0;
                    phase_next = PH_OPEN;
                    if (fin) begin
                        if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_OPEN;
                        phase_next = PH_SKIP;
                    end
                end else begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_FIRST;
                    phase_next = PH_SKIP;
                end
            end
        endcase

        // Quoted body byte
        if (do_quoted) begin
            if (fin) begin
                if (b != quote_reg) begin
                    if (err_next == slu_pkg::ERR_NONE) err_next = slu_pkg::ERR_QUOTE;
                    phase_next = PH_SKIP;
                end
            end else if (b == slu_pkg::CH_BSL) begin
                phase_next = PH_ESCAPE;
            end else begin
                if (put_n == 2'd0) begin
                    put_b0 = b;
                end else begin
                    put_b1 = b;
                end
                put_n = put_n + 2'd1;
            end
        end

        // Error code of this beat before the end-of-literal clear
        err_next_final = err_next;

        // End of literal: back to waiting
        if (fin) begin
            phase_next = PH_WAIT;
            quote_next = 8'd0;
            level_next = '0;
            dval_next  = 8'd0;
            dcnt_next  = 2'd0;
            first_next = 1'b1;
            fill_next  = '0;
            err_next   = slu_pkg::ERR_NONE;
        end
    end

    // Result beats for this input
    always_comb begin
        res0 = '0;
        res1 = '0;
        if (put_n == 2'd0) begin
            res_n = 2'd1;
        end else begin
            res_n           = put_n;
            res0.out_byte   = put_b0;
            res0.byte_valid = 1'b1;
            res1.out_byte   = put_b1;
            res1.byte_valid = 1'b1;
        end
        if (res_n == 2'd1) begin
            res0.run_last     = 1'b1;
            res0.literal_done = fin;
            res0.error_code   = fin ? err_next_final : slu_pkg::ERR_NONE;
        end else begin
            res1.run_last     = 1'b1;
            res1.literal_done = fin;
            res1.error_code   = fin ? err_next_final : slu_pkg::ERR_NONE;
        end
    end

    // Result queue update: pop from the head, push behind what remains
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                q_next[i] = q_reg[(i + 1) % QDEPTH];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (accept) begin
                if (2'(i) == cnt_pop) begin
                    q_next[i] = res0;
                end else if (2'(i) == cnt_pop + 2'd1 && res_n == 2'd2) begin
                    q_next[i] = res1;
                end
            end
        end
        cnt_next = cnt_pop + (accept ? res_n : 2'd0);
    end

    // State and queue registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            quote_reg <= 8'd0;
            level_reg <= '0;
            dval_reg  <= 8'd0;
            dcnt_reg  <= 2'd0;
            first_reg <= 1'b1;
            fill_reg  <= '0;
            err_reg   <= slu_pkg::ERR_NONE;
            cnt_reg   <= 2'd0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                quote_reg <= quote_next;
                level_reg <= level_next;
                dval_reg  <= dval_next;
                dcnt_reg  <= dcnt_next;
                first_reg <= first_next;
                fill_reg  <= fill_next;
                err_reg   <= err_next;
            end
            cnt_reg <= cnt_next;
        end
        if (accept) begin
            tail_reg <= tail_next;
        end
        q_reg <= q_next;
    end

endmodule

/* design/slu_checker.sv */
// Port-level checks for string_literal_unescaper_core.
// Holds the checker module and its bind statement; depends on slu_pkg.
module slu_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input slu_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input slu_pkg::out_item_t m_result
);

    // End of literal is always the last beat of its run
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.literal_done |-> m_result.run_last)
        else $error("literal_done without run_last");

    // Error codes only appear when a literal ends
    a_err_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.error_code != slu_pkg::ERR_NONE |-> m_result.literal_done)
        else $error("error_code outside end of literal");

    // Empty beats carry a zero byte
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.byte_valid |-> m_result.out_byte == 8'd0)
        else $error("out_byte nonzero on empty beat");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result beat changed while stalled");

    // A waiting input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input beat changed while waiting");

endmodule

bind string_literal_unescaper_core slu_checker u_slu_checker (.*);
